// ===== src/escape_key_byte_unstuffer_defines.svh =====
// ----------------------------------------------------------------------------
// Escape key byte unstuffer assertion macros
// Concurrent assertion wrappers, compiled out when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef ESCAPE_KEY_BYTE_UNSTUFFER_DEFINES_SVH
`define ESCAPE_KEY_BYTE_UNSTUFFER_DEFINES_SVH

`ifndef ASSERT_OFF
// check under reset qualification
`define EKBU_ASSERT_RST(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("ekbu assertion failed");
// check at every edge
`define EKBU_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) (prop)) \
        else $error("ekbu assertion failed");
`else
`define EKBU_ASSERT_RST(name, clk, rst_n, prop)
`define EKBU_ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

// ===== src/ekbu_pkg.sv =====
// ----------------------------------------------------------------------------
// Escape key byte unstuffer package
// Key table, result kinds and controller/datapath command and status types.
// ----------------------------------------------------------------------------
package ekbu_pkg;

    localparam int unsigned KEY_LEN      = 12;
    localparam logic [3:0]  KEY_LAST_IDX = 4'(KEY_LEN - 1);
    localparam logic [16:0] PAUSE_MARGIN = 17'd14;
    localparam logic [7:0]  STUFF_CHAR   = 8'h58;
    localparam logic [15:0] CAP_RESET    = 16'd4096;

    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_KEY   = 2'd1;
    localparam logic [1:0] KIND_PAUSE = 2'd2;
    localparam logic [1:0] KIND_EOS   = 2'd3;

    // end key bytes, first character at index 0
    function automatic logic [7:0] key_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h66;
            4'd1:    c = 8'h74;
            4'd2:    c = 8'h5F;
            4'd3:    c = 8'h53;
            4'd4:    c = 8'h74;
            4'd5:    c = 8'h55;
            4'd6:    c = 8'h66;
            4'd7:    c = 8'h46;
            4'd8:    c = 8'h5F;
            4'd9:    c = 8'h6B;
            4'd10:   c = 8'h65;
            4'd11:   c = 8'h79;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    typedef struct packed {
        logic       load;
        logic       inc_match;
        logic       clr_match;
        logic       clr_count;
        logic       emit;
        logic [1:0] emit_kind;
        logic       emit_prefix;
        logic       emit_last;
        logic       flush_adv;
    } ekbu_cmd_t;

    typedef struct packed {
        logic slot_free;
        logic eos;
        logic key_hit;
        logic key_done;
        logic stuffed;
        logic held_zero;
        logic flush_last;
        logic pause_data;
        logic pause_now;
    } ekbu_sts_t;

endpackage

// ===== src/ekbu_in_if.sv =====
// ----------------------------------------------------------------------------
// Escape key byte unstuffer input channel
// Valid/ready channel carrying one received stream byte per item.
// ----------------------------------------------------------------------------
interface ekbu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_stream;

    modport source (output valid, output in_byte, output end_of_stream, input ready);
    modport sink (input valid, input in_byte, input end_of_stream, output ready);
endinterface

// ===== src/ekbu_out_if.sv =====
// ----------------------------------------------------------------------------
// Escape key byte unstuffer result channel
// Valid/ready channel carrying one result item: kind, byte and run end flag.
// ----------------------------------------------------------------------------
interface ekbu_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic       last_of_run;

    modport source (output valid, output kind, output out_byte, output last_of_run,
                    input ready);
    modport sink (input valid, input kind, input out_byte, input last_of_run,
                  output ready);
endinterface

// ===== src/ekbu_ctrl.sv =====
// ----------------------------------------------------------------------------
// Escape key byte unstuffer controller
// Sequences accept, prefix flush, data, key, pause and end of stream results.
// ----------------------------------------------------------------------------
module ekbu_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  ekbu_pkg::ekbu_sts_t   sts,
    output ekbu_pkg::ekbu_cmd_t   cmd
);
    import ekbu_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FLUSH = 3'd1;
    localparam logic [2:0] S_BYTE  = 3'd2;
    localparam logic [2:0] S_KEY   = 3'd3;
    localparam logic [2:0] S_PAUSE = 3'd4;
    localparam logic [2:0] S_EOS   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       with_byte_reg;
    logic       with_byte_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        with_byte_next = with_byte_reg;
        cmd            = '0;
        cmd.emit_kind  = KIND_DATA;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (sts.eos)
                    begin
                        cmd.clr_match = 1'b1;
                        cmd.clr_count = 1'b1;
                        state_next    = S_EOS;
                    end
                    else if (sts.key_hit)
                    begin
                        if (sts.key_done)
                        begin
                            cmd.clr_match = 1'b1;
                            cmd.clr_count = 1'b1;
                            state_next    = S_KEY;
                        end
                        else
                        begin
                            cmd.inc_match = 1'b1;
                        end
                    end
                    else if (sts.stuffed)
                    begin
                        // drop the stuffed X, flush the prefix only
                        with_byte_next = 1'b0;
                        state_next     = S_FLUSH;
                    end
                    else
                    begin
                        with_byte_next = 1'b1;
                        state_next     = sts.held_zero ? S_BYTE : S_FLUSH;
                    end
                end
            end
            S_FLUSH:
            begin
                if (sts.slot_free)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_prefix = 1'b1;
                    cmd.flush_adv   = 1'b1;
                    if (sts.flush_last)
                    begin
                        cmd.clr_match = 1'b1;
                        if (with_byte_reg)
                        begin
                            state_next = S_BYTE;
                        end
                        else
                        begin
                            cmd.emit_last = !sts.pause_data;
                            state_next    = sts.pause_data ? S_PAUSE : S_IDLE;
                        end
                    end
                end
            end
            S_BYTE:
            begin
                if (sts.slot_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_last = !sts.pause_data;
                    state_next    = sts.pause_data ? S_PAUSE : S_IDLE;
                end
            end
            S_KEY:
            begin
                if (sts.slot_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = KIND_KEY;
                    cmd.emit_last = !sts.pause_now;
                    state_next    = sts.pause_now ? S_PAUSE : S_IDLE;
                end
            end
            S_PAUSE:
            begin
                if (sts.slot_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = KIND_PAUSE;
                    cmd.emit_last = 1'b1;
                    cmd.clr_count = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_EOS:
            begin
                if (sts.slot_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = KIND_EOS;
                    cmd.emit_last = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            with_byte_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            with_byte_reg <= with_byte_next;
        end
    end

endmodule

// ===== src/ekbu_dp.sv =====
// ----------------------------------------------------------------------------
// Escape key byte unstuffer datapath
// Match length, output count, capacity register, flush index, input byte and result register.
// ----------------------------------------------------------------------------
module ekbu_dp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [7:0]            in_byte,
    input  logic                  end_of_stream,
    input  logic                  cfg_wr_en,
    input  logic [15:0]           cfg_wr_data,
    input  ekbu_pkg::ekbu_cmd_t   cmd,
    output ekbu_pkg::ekbu_sts_t   sts,
    ekbu_out_if.source            result
);
    import ekbu_pkg::*;

    logic [3:0]  match_reg;
    logic [3:0]  match_next;
    logic [15:0] count_reg;
    logic [15:0] count_next;
    logic [15:0] cap_reg;
    logic [7:0]  byte_reg;
    logic [3:0]  flush_idx_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [1:0]  out_kind_reg;
    logic [7:0]  out_byte_reg;
    logic        out_last_reg;
    logic [7:0]  emit_byte;
    logic [15:0] count_inc;

    assign count_inc = count_reg + 16'd1;

    always_comb
    begin
        sts.slot_free  = !out_valid_reg || result.ready;
        sts.eos        = end_of_stream;
        sts.key_hit    = (in_byte == key_char(match_reg));
        sts.key_done   = (match_reg == KEY_LAST_IDX);
        sts.stuffed    = (in_byte == STUFF_CHAR) && (match_reg == KEY_LAST_IDX);
        sts.held_zero  = (match_reg == 4'd0);
        sts.flush_last = (flush_idx_reg == (match_reg - 4'd1));
        // count after one more data byte, compared without wrap of the margin add
        sts.pause_data = ({1'b0, count_inc} + PAUSE_MARGIN) >= {1'b0, cap_reg};
        sts.pause_now  = ({1'b0, count_reg} + PAUSE_MARGIN) >= {1'b0, cap_reg};
    end

    always_comb
    begin
        if (cmd.emit_kind != KIND_DATA)
        begin
            emit_byte = 8'h00;
        end
        else if (cmd.emit_prefix)
        begin
            emit_byte = key_char(flush_idx_reg);
        end
        else
        begin
            emit_byte = byte_reg;
        end
    end

    always_comb
    begin
        match_next = match_reg;
        if (cmd.clr_match)
        begin
            match_next = 4'd0;
        end
        else if (cmd.inc_match)
        begin
            match_next = match_reg + 4'd1;
        end

        count_next = count_reg;
        if (cmd.clr_count)
        begin
            count_next = 16'd0;
        end
        else if (cmd.emit && (cmd.emit_kind == KIND_DATA))
        begin
            count_next = count_inc;
        end

        out_valid_next = out_valid_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg     <= 4'd0;
            count_reg     <= 16'd0;
            cap_reg       <= CAP_RESET;
            flush_idx_reg <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            match_reg     <= match_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                cap_reg <= cfg_wr_data;
            end
            if (cmd.load)
            begin
                flush_idx_reg <= 4'd0;
            end
            else if (cmd.flush_adv)
            begin
                flush_idx_reg <= flush_idx_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            byte_reg <= in_byte;
        end
        if (cmd.emit)
        begin
            out_kind_reg <= cmd.emit_kind;
            out_byte_reg <= emit_byte;
            out_last_reg <= cmd.emit_last;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.kind        = out_kind_reg;
    assign result.out_byte    = out_byte_reg;
    assign result.last_of_run = out_last_reg;

endmodule

// ===== src/escape_key_byte_unstuffer.sv =====
// ----------------------------------------------------------------------------
// Escape key byte unstuffer
// Strips the end key from a received byte stream and flags frame end, pause
// and early stream end.
// ----------------------------------------------------------------------------
// stream carries received bytes (in_byte, end_of_stream); result carries items
// of kind data, key found, buffer full pause or stream ended, with last_of_run
// set on the final result of each input item.
// One input item at a time: stream.ready is high only while the controller is
// idle. A byte that extends a key prefix is taken with no result and leaves
// the controller idle. Any other item is accepted and then gives its results
// one at a time (up to 13: an 11-byte prefix, the byte, a pause), each one
// through the sequencing state machine and its single result register, so the
// next item waits until the last result of this one has been emitted.
// When result.ready is low the result register holds and the controller waits;
// a new item is still taken while the last result of the previous one waits.
// cfg_wr_en/cfg_wr_data write the buffer capacity; write only while idle.
// Reset clears the match length and output count, empties the result register
// and loads a capacity of 4096.
// ----------------------------------------------------------------------------
`include "escape_key_byte_unstuffer_defines.svh"

module escape_key_byte_unstuffer (
    input  logic        clk,
    input  logic        rst_n,
    ekbu_in_if.sink     stream,
    ekbu_out_if.source  result,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);
    import ekbu_pkg::*;

    ekbu_cmd_t cmd;
    ekbu_sts_t sts;
    logic      ctrl_ready;

    assign stream.ready = ctrl_ready;

    ekbu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (stream.valid),
        .in_ready (ctrl_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ekbu_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_byte       (stream.in_byte),
        .end_of_stream (stream.end_of_stream),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .cmd           (cmd),
        .sts           (sts),
        .result        (result)
    );

    `EKBU_ASSERT_RST(a_emit_needs_slot, clk, rst_n, cmd.emit |-> sts.slot_free)
    `EKBU_ASSERT_RST(a_no_emit_on_accept, clk, rst_n, (stream.valid && stream.ready) |-> !cmd.emit)
    `EKBU_ASSERT_RST(a_pause_ends_run, clk, rst_n, (result.valid && (result.kind == KIND_PAUSE || result.kind == KIND_EOS)) |-> result.last_of_run)
    `EKBU_ASSERT_RST(a_marker_zero_byte, clk, rst_n, (result.valid && result.kind != KIND_DATA) |-> (result.out_byte == 8'h00))

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Escape key byte unstuffer testbench
// Drives received bytes through the stream channel under random idling on both
// sides, predicts every result item with its own model of the key matcher and
// output counter, and checks the result channel in order, field by field.
// ----------------------------------------------------------------------------
module testbench;
    import ekbu_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE       = 16;
    localparam int IDLE_PCT     = 12;
    // end key, first character in the top byte
    localparam logic [8*12-1:0] END_KEY = 96'h6674_5F53_7455_6646_5F6B_6579;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] out_byte;
        logic       last_of_run;
    } result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;

    ekbu_in_if  stream_if ();
    ekbu_out_if result_if ();

    escape_key_byte_unstuffer u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .stream      (stream_if),
        .result      (result_if),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // predictor state
    logic [3:0]  match_len;
    logic [15:0] out_count;
    logic [15:0] capacity;
    result_t     pending_results[$];

    bit src_idle_en;
    bit snk_idle_en;
    int items_sent;
    int results_seen;
    int mismatch_count;
    int keys_found;
    int pauses_given;
    int eos_seen;
    int cycle_count;

    initial
    begin
        clk = 1'b0;
    end

    always #CLK_HALF clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic logic [7:0] key_at(input logic [3:0] idx);
        int k;
        k = 11 - int'(idx);
        return END_KEY[8*k +: 8];
    endfunction

    // Work out the result items one accepted item causes.
    function automatic void predict_item(input logic [7:0] b, input logic eos);
        logic [1:0] kinds [16];
        logic [7:0] vals [16];
        logic [3:0] held;
        result_t    r;
        int         n;
        int         i;
        n = 0;
        if (match_len >= KEY_LEN)
            match_len = 4'd0;
        if (eos)
        begin
            match_len = 4'd0;
            out_count = 16'd0;
            kinds[n] = KIND_EOS;
            vals[n] = 8'd0;
            n++;
            eos_seen++;
        end
        else if (b == key_at(match_len))
        begin
            match_len = match_len + 4'd1;
            if (match_len == KEY_LEN)
            begin
                match_len = 4'd0;
                out_count = 16'd0;
                kinds[n] = KIND_KEY;
                vals[n] = 8'd0;
                n++;
                keys_found++;
            end
        end
        else
        begin
            // flush the held prefix, then the byte unless it is a stuffed escape
            held = match_len;
            for (i = 0; i < int'(held); i++)
            begin
                kinds[n] = KIND_DATA;
                vals[n] = key_at(4'(i));
                n++;
                out_count = out_count + 16'd1;
            end
            match_len = 4'd0;
            if (!(b == STUFF_CHAR && held == KEY_LAST_IDX))
            begin
                kinds[n] = KIND_DATA;
                vals[n] = b;
                n++;
                out_count = out_count + 16'd1;
            end
        end
        if (!eos && match_len == 4'd0 && (17'(out_count) + PAUSE_MARGIN >= 17'(capacity)))
        begin
            out_count = 16'd0;
            kinds[n] = KIND_PAUSE;
            vals[n] = 8'd0;
            n++;
            pauses_given++;
        end
        for (i = 0; i < n; i++)
        begin
            r.kind = kinds[i];
            r.out_byte = vals[i];
            r.last_of_run = (i == n - 1);
            pending_results.push_back(r);
        end
    endfunction

    // Result checker and sink-side stall generator.
    always @(posedge clk)
    begin
        result_t exp_r;
        if (rst_n)
        begin
            if (result_if.valid && result_if.ready)
            begin
                results_seen++;
                if (pending_results.size() == 0)
                begin
                    $error("unexpected result: kind %0d, out_byte 0x%02h, last_of_run %0b",
                           result_if.kind, result_if.out_byte, result_if.last_of_run);
                    mismatch_count++;
                end
                else
                begin
                    exp_r = pending_results.pop_front();
                    if (result_if.kind !== exp_r.kind)
                    begin
                        $error("kind: expected %0d, actual %0d", exp_r.kind, result_if.kind);
                        mismatch_count++;
                    end
                    if (result_if.out_byte !== exp_r.out_byte)
                    begin
                        $error("out_byte: expected 0x%02h, actual 0x%02h",
                               exp_r.out_byte, result_if.out_byte);
                        mismatch_count++;
                    end
                    if (result_if.last_of_run !== exp_r.last_of_run)
                    begin
                        $error("last_of_run: expected %0b, actual %0b",
                               exp_r.last_of_run, result_if.last_of_run);
                        mismatch_count++;
                    end
                end
            end
            result_if.ready <= !(snk_idle_en && $urandom_range(99) < IDLE_PCT);
        end
    end

    // Offer one item and hold it until taken.
    task automatic send_item(input logic [7:0] b, input logic eos);
        if (src_idle_en && $urandom_range(99) < IDLE_PCT)
        begin
            stream_if.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        stream_if.valid <= 1'b1;
        stream_if.in_byte <= b;
        stream_if.end_of_stream <= eos;
        do
            @(posedge clk);
        while (!stream_if.ready);
        predict_item(b, eos);
        items_sent++;
    endtask

    task automatic send_key_prefix(input int len);
        int i;
        for (i = 0; i < len; i++)
            send_item(key_at(4'(i)), 1'b0);
    endtask

    // Drop valid, drain all expected results, then let any quiet item finish.
    task automatic wait_until_idle();
        stream_if.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [15:0] v);
        wait_until_idle();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        capacity = v;
    endtask

    task automatic test_plain_bytes();
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(STUFF_CHAR, 1'b0);
    endtask

    task automatic test_prefix_flush();
        // the byte that breaks the prefix is not retried as a key start
        send_key_prefix(2);
        send_item(key_at(4'd0), 1'b0);
        send_item(key_at(4'd11), 1'b0);
    endtask

    task automatic test_end_of_stream();
        send_item(8'hA5, 1'b1);
        send_key_prefix(3);
        send_item(8'h5A, 1'b1);
    endtask

    task automatic test_stuffed_escape_with_pause();
        send_key_prefix(11);
        send_item(STUFF_CHAR, 1'b0);
    endtask

    // Mostly key-shaped sequences with random breaks, plus raw noise.
    task automatic test_random_traffic(input int n_items);
        int start;
        int pick;
        int len;
        int i;
        logic [7:0] b;
        start = items_sent;
        while (items_sent - start < n_items)
        begin
            pick = $urandom_range(99);
            if (pick < 28)
                send_key_prefix(KEY_LEN);
            else if (pick < 50)
            begin
                len = $urandom_range(1, 11);
                send_key_prefix(len);
                case ($urandom_range(2))
                    0:       b = key_at(4'd0);
                    1:       b = STUFF_CHAR;
                    default: b = 8'($urandom_range(255));
                endcase
                send_item(b, 1'b0);
            end
            else if (pick < 60)
            begin
                send_key_prefix(11);
                send_item(STUFF_CHAR, 1'b0);
            end
            else if (pick < 68)
            begin
                send_key_prefix($urandom_range(1, 11));
                send_item(8'($urandom_range(255)), 1'b1);
            end
            else if (pick < 72)
                send_item(8'($urandom_range(255)), 1'b1);
            else
            begin
                len = $urandom_range(1, 4);
                for (i = 0; i < len; i++)
                    send_item(8'($urandom_range(255)), 1'b0);
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = 16'd0;
        stream_if.valid = 1'b0;
        stream_if.in_byte = 8'd0;
        stream_if.end_of_stream = 1'b0;
        result_if.ready = 1'b0;
        match_len = 4'd0;
        out_count = 16'd0;
        capacity = CAP_RESET;
        src_idle_en = 1'b1;
        snk_idle_en = 1'b1;
        items_sent = 0;
        results_seen = 0;
        mismatch_count = 0;
        keys_found = 0;
        pauses_given = 0;
        eos_seen = 0;
        cycle_count = 0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_plain_bytes();
        test_prefix_flush();
        test_end_of_stream();
        write_capacity(16'd15);
        test_stuffed_escape_with_pause();

        test_random_traffic(70);
        write_capacity(16'hFFFF);
        test_random_traffic(70);
        write_capacity(16'($urandom_range(16, 120)));
        test_random_traffic(70);
        // every item other than a stream end that leaves no prefix held ends in a pause
        write_capacity(16'd0);
        test_random_traffic(30);

        write_capacity(CAP_RESET);
        src_idle_en = 1'b0;
        snk_idle_en = 1'b0;
        test_random_traffic(100);
        wait_until_idle();

        $display("Sent %0d items, checked %0d results: %0d keys, %0d pauses, %0d stream ends",
                 items_sent, results_seen, keys_found, pauses_given, eos_seen);
        $display("Capacities covered: reset value, 0, 15, random small, 65535");
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
